// ===== hw/rtl/semiprime_trial_division_tester_defines.svh =====
// Assertion macros for the semiprime tester.
`ifndef SEMIPRIME_TRIAL_DIVISION_TESTER_DEFINES_SVH
`define SEMIPRIME_TRIAL_DIVISION_TESTER_DEFINES_SVH
`ifndef SYNTH
`define STD_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define STD_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define STD_ASSERT_IMPL(label, clk, rst, prop)
`define STD_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== hw/rtl/stdt_pkg.sv =====
package stdt_pkg;
   localparam int VALUE_BITS_DEF = 16;
   localparam int FIELD_BITS = 16;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN_N, ST_DIV_N, ST_SCAN_Q, ST_DIV_Q, ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
   } div_ctrl_type;
endpackage

// ===== hw/rtl/stdt_divider.sv =====
module stdt_divider import stdt_pkg::*; #(
   parameter int W = VALUE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output div_ctrl_type ctrl,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  q_ff, q_in;
   logic [W-1:0]  r_ff, r_in;
   logic [W-1:0]  d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [W:0]    trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {r_ff, q_ff[W-1]};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         cnt_in = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in = {q_ff[W-2:0], 1'b0};
         if (trial >= {1'b0, d_ff}) begin
            r_in = W'(trial - {1'b0, d_ff});
            q_in[0] = 1'b1;
         end else begin
            r_in = trial[W-1:0];
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign ctrl.start = start;
   assign ctrl.busy = busy_ff;
   assign quotient = q_ff;
   assign remainder = r_ff;
endmodule

// ===== hw/rtl/semiprime_trial_division_tester.sv =====
// Each trial divisor is tested by the bit-serial divider, which is shared by both
// trial loops.
// For 16-bit values there are at most about 270 trial divisors.
// Throughput: one beat at a time; the next request is taken after the response leaves.
// Reset: synchronous, active high; clears the controller and the range flag.
module semiprime_trial_division_tester import stdt_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [FIELD_BITS-1:0] req_value,
   input  logic                  req_range_end,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_is_semiprime,
   output logic [FIELD_BITS-1:0] rsp_small_factor,
   output logic                  rsp_any_in_range,
   output logic                  rsp_last
);
`include "semiprime_trial_division_tester_defines.svh"
   localparam int W = VALUE_BITS;

   state_type    state_ff, state_in;
   logic [W-1:0] n_ff, n_in, q_ff, q_in, d_ff, d_in, p_ff, p_in;
   logic         end_ff, end_in, semi_ff, semi_in, seen_ff, seen_in;
   logic         div_start;
   logic [W-1:0] div_a, div_b, quo, rem;
   div_ctrl_type dctl;
   logic [2*W-1:0] dsq;
   logic         wait_ff, wait_in;

   stdt_divider #(.W(W)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_a),
      .divisor(div_b), .ctrl(dctl), .quotient(quo), .remainder(rem)
   );

   assign dsq = d_ff * d_ff;

   always_comb begin
      state_in = state_ff;
      n_in = n_ff; q_in = q_ff; d_in = d_ff; p_in = p_ff;
      end_in = end_ff; semi_in = semi_ff; seen_in = seen_ff;
      wait_in = wait_ff;
      div_start = 1'b0;
      div_a = (state_ff == ST_DIV_Q || state_ff == ST_SCAN_Q) ? q_ff : n_ff;
      div_b = d_ff;
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in = W'(req_value);
               end_in = req_range_end;
               semi_in = 1'b0;
               d_in = W'(2);
               state_in = (W'(req_value) >= W'(4)) ? ST_SCAN_N : ST_DONE;
            end
         end
         ST_SCAN_N: begin
            if (dsq > {{W{1'b0}}, n_ff}) begin
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               wait_in = 1'b1;
               state_in = ST_DIV_N;
            end
         end
         ST_DIV_N: begin
            if (wait_ff) wait_in = 1'b0;
            else if (!dctl.busy) begin
               if (rem == '0) begin
                  p_in = d_ff;
                  q_in = quo;
                  d_in = W'(2);
                  state_in = (quo >= W'(2)) ? ST_SCAN_Q : ST_DONE;
               end else begin
                  d_in = d_ff + W'(1);
                  state_in = ST_SCAN_N;
               end
            end
         end
         ST_SCAN_Q: begin
            if (dsq > {{W{1'b0}}, q_ff}) begin
               semi_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               wait_in = 1'b1;
               state_in = ST_DIV_Q;
            end
         end
         ST_DIV_Q: begin
            if (wait_ff) wait_in = 1'b0;
            else if (!dctl.busy) begin
               if (rem == '0) state_in = ST_DONE;
               else begin
                  d_in = d_ff + W'(1);
                  state_in = ST_SCAN_Q;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               seen_in = end_ff ? 1'b0 : (seen_ff | semi_ff);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seen_ff <= 1'b0;
         wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         seen_ff <= seen_in;
         wait_ff <= wait_in;
      end
      n_ff <= n_in; q_ff <= q_in; d_ff <= d_in; p_ff <= p_in;
      end_ff <= end_in; semi_ff <= semi_in;
   end

   assign rsp_is_semiprime = semi_ff;
   assign rsp_small_factor = semi_ff ? FIELD_BITS'(p_ff) : '0;
   assign rsp_any_in_range = seen_ff | semi_ff;
   assign rsp_last = end_ff;

   `STD_ASSERT_IMPL(a_no_start_busy, clock, reset, dctl.start |-> !dctl.busy)
   `STD_ASSERT_IMPL(a_stall_busy, clock, reset, rsp_valid |-> req_stall)
   `STD_ASSERT_IMPL(a_semi_factor, clock, reset, (rsp_valid && rsp_is_semiprime) |-> (rsp_small_factor >= 16'd2))
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top import stdt_pkg::*; ();

   localparam int  LIMIT_CYCLES = 30_000_000;
   localparam int  DRAIN_CYCLES = 200;

   typedef struct {
      logic [FIELD_BITS-1:0] value;
      logic                  range_end;
      int                    gap;
   } number_beat_type;

   typedef struct {
      logic                  is_semiprime;
      logic [FIELD_BITS-1:0] small_factor;
      logic                  any_in_range;
      logic                  last;
   } verdict_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [FIELD_BITS-1:0] req_value = '0;
   logic                  req_range_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_is_semiprime;
   logic [FIELD_BITS-1:0] rsp_small_factor;
   logic                  rsp_any_in_range;
   logic                  rsp_last;

   number_beat_type pending_numbers[$];
   verdict_type     expected_verdicts[$];
   logic         range_has_semiprime = 1'b0;
   int           gap_left = 0;
   int           stall_left = 0;
   int           numbers_sent = 0;
   int           verdicts_seen = 0;
   int           semiprimes_seen = 0;
   int           ranges_closed = 0;
   int           mismatches = 0;
   int           cycle_count = 0;
   int           total_numbers = 0;

   semiprime_trial_division_tester #(.VALUE_BITS(VALUE_BITS_DEF)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_value(req_value),
      .req_range_end(req_range_end),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_is_semiprime(rsp_is_semiprime),
      .rsp_small_factor(rsp_small_factor),
      .rsp_any_in_range(rsp_any_in_range),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic verdict_type classify_number(logic [FIELD_BITS-1:0] value,
                                                   logic range_end);
      verdict_type v;
      longint    n;
      longint    p;
      longint    q;
      longint    d;
      bit        q_prime;
      n = value & ((64'd1 << VALUE_BITS_DEF) - 1);
      v.is_semiprime = 1'b0;
      v.small_factor = '0;
      if (n >= 4) begin
         p = n;
         for (d = 2; d * d <= n; d++) begin
            if (n % d == 0) begin
               p = d;
               break;
            end
         end
         if (p < n) begin
            q = n / p;
            q_prime = (q >= 2);
            for (d = 2; d * d <= q; d++) begin
               if (q % d == 0) begin
                  q_prime = 0;
                  break;
               end
            end
            if (q_prime) begin
               v.is_semiprime = 1'b1;
               v.small_factor = p[FIELD_BITS-1:0];
            end
         end
      end
      v.any_in_range = range_has_semiprime | v.is_semiprime;
      v.last = range_end;
      return v;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch on result %0d: %s is %0d, expected %0d",
               verdicts_seen, field, got, want);
      mismatches++;
   endtask

   task automatic queue_number(int value, bit range_end, int gap);
      number_beat_type b;
      b.value = value[FIELD_BITS-1:0];
      b.range_end = range_end;
      b.gap = gap;
      pending_numbers.push_back(b);
   endtask

   function automatic int pick_value();
      int r;
      int primes[10] = '{2, 3, 5, 7, 11, 13, 31, 97, 101, 251};
      r = $urandom_range(0, 99);
      if (r < 30)
         return primes[$urandom_range(0, 9)] * primes[$urandom_range(0, 9)];
      else if (r < 85)
         return $urandom_range(0, 1023);
      else if (r < 96)
         return $urandom_range(1024, 8191);
      else
         return $urandom_range(0, 65535);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
         range_has_semiprime <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            verdict_type v;
            v = classify_number(req_value, req_range_end);
            expected_verdicts.push_back(v);
            range_has_semiprime <= req_range_end ? 1'b0 : v.any_in_range;
            numbers_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (pending_numbers.size() > 0) begin
               number_beat_type b;
               b = pending_numbers.pop_front();
               req_valid <= 1'b1;
               req_value <= b.value;
               req_range_end <= b.range_end;
               gap_left <= b.gap;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         int n_stall;
         if (expected_verdicts.size() == 0) begin
            report_mismatch("outstanding results", 0, 1);
         end else begin
            verdict_type want;
            want = expected_verdicts.pop_front();
            if (rsp_is_semiprime !== want.is_semiprime)
               report_mismatch("is_semiprime", rsp_is_semiprime, want.is_semiprime);
            if (rsp_small_factor !== want.small_factor)
               report_mismatch("small_factor", rsp_small_factor, want.small_factor);
            if (rsp_any_in_range !== want.any_in_range)
               report_mismatch("any_in_range", rsp_any_in_range, want.any_in_range);
            if (rsp_last !== want.last)
               report_mismatch("last", rsp_last, want.last);
            semiprimes_seen += want.is_semiprime;
            ranges_closed += want.last;
         end
         verdicts_seen++;
         n_stall = ((verdicts_seen % 24) < 6) ? 0 : $urandom_range(0, 6);
         stall_left <= n_stall;
         rsp_stall <= (n_stall > 0);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_verdicts.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int directed[] = '{1, 0, 2, 3, 4, 6, 9, 8, 12, 15, 25, 49, 65535, 65498,
                         64507, 65521, 65534, 32768, 21845, 43690};
      int seg_len;
      bit calm;
      queue_number(4, 1'b1, 0);
      foreach (directed[i])
         queue_number(directed[i], (i % 5) == 4, $urandom_range(0, 6));
      queue_number(7, 1'b0, 0);
      queue_number(13, 1'b1, 0);
      while (pending_numbers.size() < 100) begin
         seg_len = $urandom_range(1, 8);
         calm = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < seg_len; k++)
            queue_number(pick_value(), k == seg_len - 1,
                         calm ? 0 : $urandom_range(0, 6));
      end
      total_numbers = pending_numbers.size();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (numbers_sent == total_numbers && expected_verdicts.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("tested %0d numbers in %0d ranges, %0d of them semiprime",
               verdicts_seen, ranges_closed, semiprimes_seen);
      if (mismatches == 0 && expected_verdicts.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

// ===== semiprime_trial_division_tester.f =====
+incdir+hw/rtl
hw/rtl/stdt_pkg.sv
hw/rtl/stdt_divider.sv
hw/rtl/semiprime_trial_division_tester.sv
tb/tb_top.sv
